// ----- rtl/status_frame_serializer_crc16_macros.svh -----
// Assertion macros shared by the serializer modules.
`ifndef STATUS_FRAME_SERIALIZER_CRC16_MACROS_SVH
`define STATUS_FRAME_SERIALIZER_CRC16_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SFSC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle implies a consequence in the same cycle.
`define SFSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition in one cycle implies a consequence in the next cycle.
`define SFSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sfsc_pkg.sv -----
package sfsc_pkg;

    localparam int unsigned FRAME_BYTES = 36;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned FRAME_W     = FRAME_BYTES * 8;

    localparam logic [IDX_W-1:0] FIRST_IDX  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CRC_FIRST  = IDX_W'(2);
    localparam logic [IDX_W-1:0] CRC_LAST   = IDX_W'(31);
    localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(32);
    localparam logic [IDX_W-1:0] CRC_HI_IDX = IDX_W'(33);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);

    localparam logic [15:0] BODY_LENGTH = 16'd24;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;
    localparam int unsigned Q_CW    = 2;

    typedef enum logic [2:0] {
        REG_SOF_FIRST  = 3'd0,
        REG_SOF_SECOND = 3'd1,
        REG_VERSION    = 3'd2,
        REG_MSG_KIND   = 3'd3,
        REG_FLAGS      = 3'd4,
        REG_EOF_FIRST  = 3'd5,
        REG_EOF_SECOND = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic        [7:0]  sequence_number;
        logic        [15:0] battery_millivolts;
        logic signed [15:0] temperature;
        logic        [47:0] velocity_xyz;
        logic        [47:0] gyro_xyz;
        logic        [47:0] accel_xyz;
        logic        [15:0] status_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic [7:0] sof_first;
        logic [7:0] sof_second;
        logic [7:0] version;
        logic [7:0] msg_kind;
        logic [7:0] flags;
        logic [7:0] eof_first;
        logic [7:0] eof_second;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_head;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/sfsc_front.sv -----
`include "status_frame_serializer_crc16_macros.svh"

module sfsc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sfsc_pkg::t_in_item i_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output sfsc_pkg::t_cfg     o_cfg,
    output sfsc_pkg::t_q_head  o_head,
    input  logic               i_pop
);
    import sfsc_pkg::*;

    t_cfg            r_cfg;
    t_in_item        r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            w_push;
    logic            w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SOF_FIRST:  r_cfg.sof_first  <= i_cfg_data;
                REG_SOF_SECOND: r_cfg.sof_second <= i_cfg_data;
                REG_VERSION:    r_cfg.version    <= i_cfg_data;
                REG_MSG_KIND:   r_cfg.msg_kind   <= i_cfg_data;
                REG_FLAGS:      r_cfg.flags      <= i_cfg_data;
                REG_EOF_FIRST:  r_cfg.eof_first  <= i_cfg_data;
                REG_EOF_SECOND: r_cfg.eof_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stall = (r_count == Q_CW'(Q_DEPTH));
        w_push  = i_valid && !o_stall;
        w_pop   = i_pop && (r_count != '0);
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
        o_head.valid = (r_count != '0);
        o_head.item  = r_q[r_rd_ptr];
        o_cfg        = r_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    `SFSC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= Q_CW'(Q_DEPTH), "Queue count exceeds its depth.")
    `SFSC_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "Pop requested from an empty queue.")
    `SFSC_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "Queue count did not follow a transfer in.")

endmodule

// ----- rtl/sfsc_back.sv -----
`include "status_frame_serializer_crc16_macros.svh"

module sfsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfsc_pkg::t_cfg      i_cfg,
    input  sfsc_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output sfsc_pkg::t_out_item o_data
);
    import sfsc_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [FRAME_W-1:0] w_frame;
    logic [7:0]       w_byte;
    logic             w_load;
    logic             w_last;

    always_comb begin
        w_frame = {i_cfg.eof_second, i_cfg.eof_first, 16'h0000,
                   i_head.item.status_word, i_head.item.accel_xyz,
                   i_head.item.gyro_xyz, i_head.item.velocity_xyz,
                   i_head.item.temperature, i_head.item.battery_millivolts,
                   BODY_LENGTH, i_head.item.sequence_number, i_cfg.flags,
                   i_cfg.msg_kind, i_cfg.version, i_cfg.sof_second, i_cfg.sof_first};
        if (r_idx == CRC_LO_IDX) begin
            w_byte = r_crc[7:0];
        end else if (r_idx == CRC_HI_IDX) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = w_frame[{r_idx, 3'b000} +: 8];
        end
        w_load = i_head.valid && (!r_out_valid || !i_stall);
        w_last = (r_idx == LAST_IDX);
        o_pop  = w_load && w_last;
        n_idx  = w_last ? FIRST_IDX : r_idx + 1'b1;
        if (w_last) begin
            n_crc = CRC_INIT;
        end else if (r_idx >= CRC_FIRST && r_idx <= CRC_LAST) begin
            n_crc = crc_byte(r_crc, w_byte);
        end else begin
            n_crc = r_crc;
        end
        o_valid = r_out_valid;
        o_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= FIRST_IDX;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.frame_byte <= w_byte;
            r_out.last_byte  <= w_last;
        end
    end

    `SFSC_ASSERT_ALWAYS(a_idx_bound, i_clk, i_rst_n, r_idx <= LAST_IDX, "Byte index ran past the frame.")
    `SFSC_ASSERT_NEXT(a_wrap_after_last, i_clk, i_rst_n, w_load && w_last, r_idx == FIRST_IDX && r_crc == CRC_INIT, "Frame end did not restart the index and checksum.")
    `SFSC_ASSERT_NEXT(a_last_flag, i_clk, i_rst_n, w_load, r_out.last_byte == (r_idx == FIRST_IDX), "Last-byte flag disagrees with the byte index.")

endmodule

// ----- rtl/status_frame_serializer_crc16.sv -----
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// record   | i_valid / o_stall       | i_data   (sfsc_pkg::t_in_item)
// byte     | o_valid / i_stall       | o_data   (sfsc_pkg::t_out_item)
// config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Each record gives 36 byte transfers, one per cycle while the byte side does not stall,
// so records are taken at the pace of their frame bytes; the byte-wide output register sets this pace.
// A two-entry record queue holds up to two records, the one being sent included.
// The checksum is updated a byte per cycle as bytes 2 to 31 are loaded; the first byte is offered
// after a record taken into an empty block is written to the queue and then to the output register.
// Reset is synchronous and active low; it empties the queue, clears the header registers
// to zero and sets the checksum register to all ones.

module status_frame_serializer_crc16 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sfsc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sfsc_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import sfsc_pkg::*;

    t_cfg    w_cfg;
    t_q_head w_head;
    logic    w_pop;

    sfsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    sfsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
